// ----- rtl/ncc_pkg.sv -----
`timescale 1ns / 1ps
package ncc_pkg;

	// fixed field widths
	localparam int unsigned IDX_W    = 16;
	localparam int unsigned LOCAL_W  = 17;
	localparam int unsigned DIST_W   = 50;
	localparam int unsigned LIM_W    = 25;
	localparam int unsigned CFG_DW   = 64;
	localparam int unsigned CFG_AW   = 4;

	// clamp on the local atom count
	localparam logic [LIM_W-1:0] MAX_ATOMS = 25'd65536;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [LOCAL_W-1:0] local_t;
	typedef logic [DIST_W-1:0]  dist_t;

	// register index, taken from paddr[3] (registers sit at 8 * index)
	typedef enum logic {
		REG_LOCAL_COUNT = 1'b0,
		REG_CUTOFF_SQ   = 1'b1
	} reg_idx_t;

	// control that travels alongside the squares into the select stage
	typedef struct packed {
		logic valid;
		logic present;
		logic last;
		idx_t cand_index;
		idx_t rep_index;
	} sel_ctrl_t;

	// one segment result
	typedef struct packed {
		logic found;
		idx_t first;
		idx_t second;
		logic owner;
	} sel_res_t;

	// local when below the clamped local count
	function automatic logic is_local(input idx_t idx, input local_t lc);
		logic [LIM_W-1:0] lim;
		lim = (LIM_W'(lc) > MAX_ATOMS) ? MAX_ATOMS : LIM_W'(lc);
		return LIM_W'(idx) < lim;
	endfunction

endpackage

// ----- rtl/ncc_sqdist.sv -----
`timescale 1ns / 1ps
module ncc_sqdist #(
	parameter int unsigned COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_BITS-1:0]  rep_c_s1  [3],
	input  logic signed [COORD_BITS-1:0]  cand_c_s1 [3],
	output logic        [2*COORD_BITS-1:0] sq_s2    [3]
);

	localparam int unsigned DW = COORD_BITS + 1;

	// per axis: exact difference, magnitude, square; registered
	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [DW-1:0]         diff;
		logic        [DW-1:0]         mag_full;
		logic        [COORD_BITS-1:0] mag;

		assign diff     = DW'(cand_c_s1[k]) - DW'(rep_c_s1[k]);
		assign mag_full = diff[DW-1] ? DW'(-diff) : DW'(diff);
		// |diff| never exceeds 2^COORD_BITS - 1
		assign mag      = mag_full[COORD_BITS-1:0];

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s2[k] <= (2*COORD_BITS)'(mag) * (2*COORD_BITS)'(mag);
			end
		end
	end

endmodule

// ----- rtl/ncc_select.sv -----
`timescale 1ns / 1ps
module ncc_select
	import ncc_pkg::*;
#(
	parameter int unsigned COORD_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  sel_ctrl_t                   ctrl_s2,
	input  logic [2*COORD_BITS-1:0]     sq_s2 [3],
	input  local_t                      local_count,
	input  dist_t                       cutoff_sq,
	output sel_res_t                    res
);

	localparam int unsigned SQ_W  = 2 * COORD_BITS;
	localparam int unsigned SUM_W = SQ_W + 2;
	localparam int unsigned CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	idx_t             best_index_q;
	dist_t            best_dist_q;
	logic             have_q;

	logic [SUM_W-1:0] sum;
	logic [CMP_W-1:0] sum_ext;
	logic             kept;
	logic             win_now;
	logic             have_eff;
	idx_t             best_eff;
	logic             rep_loc;
	logic             win_loc;

	// squared distance (fits in 50 bits); anything past the cutoff drops
	assign sum     = SUM_W'(sq_s2[0]) + SUM_W'(sq_s2[1]) + SUM_W'(sq_s2[2]);
	assign sum_ext = CMP_W'(sum);
	assign kept    = ctrl_s2.present && (sum_ext <= CMP_W'(cutoff_sq));
	assign win_now = kept && (!have_q || (sum_ext[DIST_W-1:0] < best_dist_q));

	// view including this beat's candidate
	assign have_eff = have_q || win_now;
	assign best_eff = win_now ? ctrl_s2.cand_index : best_index_q;

	// ownership rule
	assign rep_loc = is_local(ctrl_s2.rep_index, local_count);
	assign win_loc = is_local(best_eff, local_count);

	always_comb begin
		res = '0;
		if (have_eff && rep_loc) begin
			res.found  = 1'b1;
			res.first  = ctrl_s2.rep_index;
			res.second = best_eff;
			res.owner  = 1'b1;
		end else if (have_eff && win_loc) begin
			res.found  = 1'b1;
			res.first  = best_eff;
			res.second = ctrl_s2.rep_index;
			res.owner  = 1'b0;
		end
	end

	// running minimum, cleared at segment end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_index_q <= '0;
			best_dist_q  <= '0;
			have_q       <= 1'b0;
		end else if (en && ctrl_s2.valid) begin
			if (ctrl_s2.last) begin
				best_index_q <= '0;
				best_dist_q  <= '0;
				have_q       <= 1'b0;
			end else if (win_now) begin
				best_index_q <= ctrl_s2.cand_index;
				best_dist_q  <= sum_ext[DIST_W-1:0];
				have_q       <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/nearest_candidate_contact_select_unit.sv -----
`timescale 1ns / 1ps
// Nearest-candidate contact selector. Takes one candidate beat per cycle
// while not stalled, measures its squared distance to the segment
// representative, keeps the first strictly nearest candidate within
// cutoff_sq (equal is kept), and on the segment's last beat returns one
// result beat with the contact pair and ownership. Three register stages
// (input, per-axis squares, result) lie between the accepted closing beat
// and out_valid; beats flow at a sustained rate of one beat per cycle when
// not stalled; the only back-to-back dependence is the compare-and-keep loop
// in the select stage. The pipeline stalls only when a segment result reaches
// a held output register; in_ready follows out_ready in the same cycle.
// Registers: local_count at 0x0, cutoff_sq at 0x8 (64-bit APB).
module nearest_candidate_contact_select_unit
	import ncc_pkg::*;
#(
	parameter int unsigned COORD_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [CFG_AW-1:0]             paddr,
	input  logic [CFG_DW-1:0]             pwdata,
	output logic [CFG_DW-1:0]             prdata,
	output logic                          pready,
	// candidate stream
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [IDX_W-1:0]              rep_index,
	input  logic signed [COORD_BITS-1:0]  rep_x,
	input  logic signed [COORD_BITS-1:0]  rep_y,
	input  logic signed [COORD_BITS-1:0]  rep_z,
	input  logic                          cand_present,
	input  logic [IDX_W-1:0]              cand_index,
	input  logic signed [COORD_BITS-1:0]  cand_x,
	input  logic signed [COORD_BITS-1:0]  cand_y,
	input  logic signed [COORD_BITS-1:0]  cand_z,
	input  logic                          last_in_segment,
	// contact results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          contact_found,
	output logic [IDX_W-1:0]              first_atom,
	output logic [IDX_W-1:0]              second_atom,
	output logic                          owner_computes
);

	local_t                         local_count_q;
	dist_t                          cutoff_sq_q;
	reg_idx_t                       reg_sel;

	logic                           en;
	logic                           stall;
	logic                           load_res;

	logic                           valid_s1;
	logic                           present_s1;
	logic                           last_s1;
	idx_t                           cand_index_s1;
	idx_t                           rep_index_s1;
	logic signed [COORD_BITS-1:0]   rep_c_s1  [3];
	logic signed [COORD_BITS-1:0]   cand_c_s1 [3];

	sel_ctrl_t                      ctrl_s2;
	logic [2*COORD_BITS-1:0]        sq_s2 [3];
	sel_res_t                       res;

	sel_res_t                       res_q;
	logic                           out_valid_q;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_count_q <= '0;
			cutoff_sq_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_sel)
				REG_LOCAL_COUNT: local_count_q <= pwdata[LOCAL_W-1:0];
				REG_CUTOFF_SQ:   cutoff_sq_q   <= pwdata[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LOCAL_COUNT: prdata = CFG_DW'(local_count_q);
			REG_CUTOFF_SQ:   prdata = CFG_DW'(cutoff_sq_q);
			default:         prdata = '0;
		endcase
	end

	// pipeline advance: hold only when a result meets a full output register
	assign stall    = ctrl_s2.valid && ctrl_s2.last && out_valid_q && !out_ready;
	assign en       = !stall;
	assign in_ready = en;
	assign load_res = en && ctrl_s2.valid && ctrl_s2.last;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			present_s1    <= cand_present;
			last_s1       <= last_in_segment;
			cand_index_s1 <= cand_index;
			rep_index_s1  <= rep_index;
			rep_c_s1[0]   <= rep_x;
			rep_c_s1[1]   <= rep_y;
			rep_c_s1[2]   <= rep_z;
			cand_c_s1[0]  <= cand_x;
			cand_c_s1[1]  <= cand_y;
			cand_c_s1[2]  <= cand_z;
		end
	end

	// squares stage
	ncc_sqdist #(
		.COORD_BITS (COORD_BITS)
	) u_sqdist (
		.clk       (clk),
		.en        (en),
		.rep_c_s1  (rep_c_s1),
		.cand_c_s1 (cand_c_s1),
		.sq_s2     (sq_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2.valid      <= valid_s1;
			ctrl_s2.present    <= present_s1;
			ctrl_s2.last       <= last_s1;
			ctrl_s2.cand_index <= cand_index_s1;
			ctrl_s2.rep_index  <= rep_index_s1;
		end
	end

	// compare-and-keep, ownership
	ncc_select #(
		.COORD_BITS (COORD_BITS)
	) u_select (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ctrl_s2     (ctrl_s2),
		.sq_s2       (sq_s2),
		.local_count (local_count_q),
		.cutoff_sq   (cutoff_sq_q),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign contact_found  = res_q.found;
	assign first_atom     = res_q.first;
	assign second_atom    = res_q.second;
	assign owner_computes = res_q.owner;

	// input side stalls only behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("in_ready low without a held result");

	// a finishing segment always lands in the output register
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		load_res |=> out_valid)
		else $error("segment result lost");

	// no-contact results carry all-zero fields
	a_no_contact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !contact_found) |->
			(first_atom == '0 && second_atom == '0 && !owner_computes))
		else $error("no-contact result with nonzero fields");

endmodule

// ----- tb/nearest_candidate_contact_select_unit_test.sv -----
`timescale 1ns / 1ps
import ncc_pkg::*;

localparam int CW = 24;
localparam longint unsigned DIST_TOP = (64'd1 << DIST_W) - 64'd1;

typedef logic signed [CW-1:0] coord_t;

// one candidate beat as offered on the input channel
typedef struct {
	idx_t   rep_index;
	coord_t rep_x;
	coord_t rep_y;
	coord_t rep_z;
	logic   cand_present;
	idx_t   cand_index;
	coord_t cand_x;
	coord_t cand_y;
	coord_t cand_z;
	logic   last;
} cand_beat_t;

// mirrors the register file and the running nearest pick, holds expected contacts
class contact_scoreboard;
	local_t   local_count;
	dist_t    cutoff_sq;
	idx_t     nearest_idx;
	dist_t    nearest_dist;
	bit       have_nearest;
	sel_res_t contacts_due[$];
	int       errors;
	int       beats;
	int       segments;
	int       contacts;
	int       checked;

	function new();
		local_count  = '0;
		cutoff_sq    = '0;
		nearest_idx  = '0;
		nearest_dist = '0;
		have_nearest = 1'b0;
		errors       = 0;
		beats        = 0;
		segments     = 0;
		contacts     = 0;
		checked      = 0;
	endfunction

	function void write_reg(reg_idx_t r, logic [CFG_DW-1:0] v);
		if (r == REG_LOCAL_COUNT) begin
			local_count = local_t'(v);
		end else begin
			cutoff_sq = dist_t'(v);
		end
	endfunction

	// atoms below the (clamped) local count are owned here
	function bit owned(idx_t idx);
		int unsigned lim = local_count;
		if (lim > MAX_ATOMS)
			lim = MAX_ATOMS;
		return idx < lim;
	endfunction

	function longint unsigned axis_sq(coord_t a, coord_t b);
		longint d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return unsigned'(d * d);
	endfunction

	function void note_input(cand_beat_t b);
		longint unsigned d;
		sel_res_t res;
		beats++;
		// compare-and-keep: within cutoff (inclusive), strictly nearer replaces
		if (b.cand_present) begin
			d = axis_sq(b.rep_x, b.cand_x) + axis_sq(b.rep_y, b.cand_y)
				+ axis_sq(b.rep_z, b.cand_z);
			if (d <= DIST_TOP && d <= cutoff_sq && (!have_nearest || d < nearest_dist)) begin
				nearest_dist = dist_t'(d);
				nearest_idx  = b.cand_index;
				have_nearest = 1'b1;
			end
		end
		if (!b.last)
			return;
		// ownership rule on the segment's closing beat
		res = '0;
		if (have_nearest) begin
			if (owned(b.rep_index)) begin
				res.found  = 1'b1;
				res.first  = b.rep_index;
				res.second = nearest_idx;
				res.owner  = 1'b1;
			end else if (owned(nearest_idx)) begin
				res.found  = 1'b1;
				res.first  = nearest_idx;
				res.second = b.rep_index;
				res.owner  = 1'b0;
			end
		end
		if (res.found)
			contacts++;
		segments++;
		contacts_due = {contacts_due, res};
		nearest_idx  = '0;
		nearest_dist = '0;
		have_nearest = 1'b0;
	endfunction

	task report_mismatch(string what);
		$display("MISMATCH: %s", what);
		errors++;
	endtask

	task check_result(sel_res_t got);
		sel_res_t want;
		if (contacts_due.size() == 0) begin
			report_mismatch($sformatf("unexpected result beat found=%0b first=%0d second=%0d owner=%0b",
				got.found, got.first, got.second, got.owner));
			return;
		end
		want = contacts_due.pop_front();
		checked++;
		if (got.found !== want.found)
			report_mismatch($sformatf("result %0d contact_found %0b, want %0b",
				checked, got.found, want.found));
		if (got.first !== want.first)
			report_mismatch($sformatf("result %0d first_atom %0d, want %0d",
				checked, got.first, want.first));
		if (got.second !== want.second)
			report_mismatch($sformatf("result %0d second_atom %0d, want %0d",
				checked, got.second, want.second));
		if (got.owner !== want.owner)
			report_mismatch($sformatf("result %0d owner_computes %0b, want %0b",
				checked, got.owner, want.owner));
	endtask

	task report_leftover();
		while (contacts_due.size() > 0) begin
			void'(contacts_due.pop_front());
			report_mismatch("expected result never arrived");
		end
	endtask
endclass

module nearest_candidate_contact_select_unit_test;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE      = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int CMIN        = -(1 << (CW - 1));
	localparam int CMAX        = (1 << (CW - 1)) - 1;

	logic                clk             = 1'b0;
	logic                arst_n          = 1'b0;
	logic                psel            = 1'b0;
	logic                penable         = 1'b0;
	logic                pwrite          = 1'b0;
	logic [CFG_AW-1:0]   paddr           = '0;
	logic [CFG_DW-1:0]   pwdata          = '0;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;
	logic                in_valid        = 1'b0;
	logic                in_ready;
	idx_t                rep_index       = '0;
	coord_t              rep_x           = '0;
	coord_t              rep_y           = '0;
	coord_t              rep_z           = '0;
	logic                cand_present    = 1'b0;
	idx_t                cand_index      = '0;
	coord_t              cand_x          = '0;
	coord_t              cand_y          = '0;
	coord_t              cand_z          = '0;
	logic                last_in_segment = 1'b0;
	logic                out_valid;
	logic                out_ready       = 1'b0;
	logic                contact_found;
	idx_t                first_atom;
	idx_t                second_atom;
	logic                owner_computes;

	contact_scoreboard sb = new();

	int idle_pct    = 22;
	int hold_req    = 0;
	int hold_left   = 0;
	int beats_sent  = 0;
	int settings    = 0;
	int cycle_count = 0;

	nearest_candidate_contact_select_unit #(
		.COORD_BITS(CW)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rep_index(rep_index),
		.rep_x(rep_x),
		.rep_y(rep_y),
		.rep_z(rep_z),
		.cand_present(cand_present),
		.cand_index(cand_index),
		.cand_x(cand_x),
		.cand_y(cand_y),
		.cand_z(cand_z),
		.last_in_segment(last_in_segment),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.contact_found(contact_found),
		.first_atom(first_atom),
		.second_atom(second_atom),
		.owner_computes(owner_computes)
	);

	always #5 clk = ~clk;

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("nearest_candidate_contact_select_unit_test: errors");
		$finish;
	end

	// result side: check accepted beats, then pick next ready (random or long hold)
	always @(posedge clk) begin : result_sink
		sel_res_t got;
		if (arst_n && out_valid && out_ready) begin
			got.found  = contact_found;
			got.first  = first_atom;
			got.second = second_atom;
			got.owner  = owner_computes;
			sb.check_result(got);
		end
		if (hold_req != 0) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	// register write: setup, access, then back to idle
	task automatic apb_write(reg_idx_t r, logic [CFG_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_reg(r, v);
		@(posedge clk);
	endtask

	// offer one candidate beat, with random leading gaps, and hold until taken
	task automatic offer(cand_beat_t b);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		rep_index       <= b.rep_index;
		rep_x           <= b.rep_x;
		rep_y           <= b.rep_y;
		rep_z           <= b.rep_z;
		cand_present    <= b.cand_present;
		cand_index      <= b.cand_index;
		cand_x          <= b.cand_x;
		cand_y          <= b.cand_y;
		cand_z          <= b.cand_z;
		last_in_segment <= b.last;
		do @(posedge clk); while (!in_ready);
		sb.note_input(b);
		beats_sent++;
	endtask

	// wait for outstanding contacts, then let the pipe empty
	task automatic drain(int max_wait);
		int waited = 0;
		while (sb.contacts_due.size() > 0 && waited < max_wait) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic cand_beat_t mk(idx_t ri, int rx, int ry, int rz, bit p, idx_t ci,
		int cx, int cy, int cz, bit l);
		cand_beat_t b;
		b.rep_index    = ri;
		b.rep_x        = coord_t'(rx);
		b.rep_y        = coord_t'(ry);
		b.rep_z        = coord_t'(rz);
		b.cand_present = p;
		b.cand_index   = ci;
		b.cand_x       = coord_t'(cx);
		b.cand_y       = coord_t'(cy);
		b.cand_z       = coord_t'(cz);
		b.last         = l;
		return b;
	endfunction

	// index biased toward local, ghost and the local/ghost boundary
	function automatic idx_t pick_index();
		int unsigned lim = sb.local_count;
		if (lim > MAX_ATOMS)
			lim = MAX_ATOMS;
		case ($urandom_range(0, 3))
			0: return idx_t'($urandom);
			1: return (lim > 0) ? idx_t'($urandom_range(0, lim - 1)) : idx_t'($urandom);
			2: return (lim < MAX_ATOMS) ? idx_t'($urandom_range(lim, 65535)) : idx_t'($urandom);
			default: return idx_t'(lim + $urandom_range(0, 2) - 1);
		endcase
	endfunction

	function automatic coord_t pick_coord();
		if ($urandom_range(0, 9) < 3)
			return coord_t'($urandom);
		return coord_t'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
	endfunction

	// per-axis offset: wide spread, around the cutoff radius, or well inside it
	function automatic int axis_offset(int r);
		int k;
		case ($urandom_range(0, 3))
			0: begin
				k = $urandom_range(0, 14);
				return int'($urandom_range(0, 2 << k)) - (1 << k);
			end
			1: return int'($urandom_range(0, 2 * r)) - r;
			default: return int'($urandom_range(0, r + 1)) - (r / 2);
		endcase
	endfunction

	// one segment of random length; mostly well-formed, some noise and empties
	task automatic run_segment(int r);
		int n;
		int kind;
		int ax;
		int o[3];
		int prev[3];
		bit moving_rep;
		bit empty_seg;
		cand_beat_t b;
		cand_beat_t nb;
		n          = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 12);
		moving_rep = ($urandom_range(0, 9) == 0);
		empty_seg  = (n == 1) && ($urandom_range(0, 2) == 0);
		b.rep_index = pick_index();
		b.rep_x     = pick_coord();
		b.rep_y     = pick_coord();
		b.rep_z     = pick_coord();
		prev = '{0, 0, 0};
		for (int i = 0; i < n; i++) begin
			if (moving_rep) begin
				b.rep_index = pick_index();
				b.rep_x     = pick_coord();
				b.rep_y     = pick_coord();
				b.rep_z     = pick_coord();
			end
			kind           = $urandom_range(0, 99);
			b.cand_present = !empty_seg && (kind >= 6);
			b.cand_index   = pick_index();
			b.last         = (i == n - 1);
			o = '{axis_offset(r), axis_offset(r), axis_offset(r)};
			if (kind >= 14 && kind < 24) begin
				// exactly on the cutoff radius
				o = '{0, 0, 0};
				ax = $urandom_range(0, 2);
				o[ax] = $urandom_range(0, 1) ? r : -r;
			end else if (kind >= 24 && kind < 28) begin
				// just past the cutoff radius
				o = '{0, 0, 0};
				ax = $urandom_range(0, 2);
				o[ax] = $urandom_range(0, 1) ? r + 1 : -r - 1;
			end else if (kind >= 28 && kind < 38) begin
				// same offset as the previous candidate: tie
				o = prev;
			end
			prev = o;
			b.cand_x = coord_t'(int'(b.rep_x) + o[0]);
			b.cand_y = coord_t'(int'(b.rep_y) + o[1]);
			b.cand_z = coord_t'(int'(b.rep_z) + o[2]);
			if (kind >= 6 && kind < 14) begin
				// noise: every field random apart from the segment marker
				nb              = b;
				nb.rep_index    = idx_t'($urandom);
				nb.rep_x        = coord_t'($urandom);
				nb.rep_y        = coord_t'($urandom);
				nb.rep_z        = coord_t'($urandom);
				nb.cand_present = !empty_seg && $urandom_range(0, 1);
				nb.cand_index   = idx_t'($urandom);
				nb.cand_x       = coord_t'($urandom);
				nb.cand_y       = coord_t'($urandom);
				nb.cand_z       = coord_t'($urandom);
				offer(nb);
			end else begin
				offer(b);
			end
		end
	endtask

	task automatic set_config(local_t lc, dist_t cut);
		apb_write(REG_LOCAL_COUNT, ({$urandom, $urandom} & ~64'h1FFFF) | CFG_DW'(lc));
		apb_write(REG_CUTOFF_SQ, ({$urandom, $urandom} & ~CFG_DW'(DIST_TOP)) | CFG_DW'(cut));
		settings++;
	endtask

	task automatic run_phase(local_t lc, dist_t cut, int r, int n_beats, int idle, bit squeeze);
		int start;
		set_config(lc, cut);
		idle_pct = idle;
		if (squeeze)
			hold_req = 1;
		start = beats_sent;
		while (beats_sent - start < n_beats)
			run_segment(r);
		in_valid <= 1'b0;
		drain(5000);
	endtask

	initial begin : main_seq
		int r;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cutoff radius 1.0, atoms 0..9 local
		set_config(17'd10, dist_t'(64'd1 << 24));
		offer(mk(3, 0, 0, 0, 0, 9, 0, 0, 0, 1));               // empty segment
		offer(mk(3, 0, 0, 0, 1, 20, 4096, 0, 0, 0));           // on cutoff, kept
		offer(mk(3, 0, 0, 0, 1, 21, 4097, 0, 0, 0));           // past cutoff
		offer(mk(3, 0, 0, 0, 1, 22, 0, 100, 0, 0));            // nearer, wins
		offer(mk(3, 0, 0, 0, 1, 23, 0, 0, -100, 0));           // tie, first stays
		offer(mk(3, 0, 0, 0, 0, 24, 0, 0, 0, 1));              // closing beat w/o candidate
		offer(mk(4, 100, -100, 0, 1, 16, 100, 3997, 0, 0));    // just past cutoff
		offer(mk(4, 100, -100, 0, 1, 15, 100, 3996, 0, 1));    // on cutoff, sole winner
		offer(mk(40, 0, 0, 0, 1, 7, 10, 10, 10, 1));           // ghost rep, local winner
		offer(mk(40, 0, 0, 0, 1, 50, 1, 1, 1, 1));             // both ghosts
		offer(mk(41, 5, 5, 5, 1, 2, 205, 5, 5, 0));            // local but farther
		offer(mk(41, 5, 5, 5, 1, 60, 15, 5, 5, 1));            // ghost winner, no contact
		offer(mk(12, 0, 0, 0, 1, 1, 50, 0, 0, 0));             // rep changes mid-segment
		offer(mk(5, 1000, 0, 0, 1, 30, 1020, 0, 0, 1));
		offer(mk(4, 0, 0, 0, 1, 5, 0, 0, 5000, 1));            // nothing within cutoff
		in_valid <= 1'b0;
		drain(5000);

		// directed: widest cutoff, local count above the clamp, coordinate extremes
		set_config(17'h1FFFF, dist_t'(DIST_TOP));
		offer(mk(16'hFFFF, CMIN, CMIN, CMIN, 1, 0, CMAX, CMAX, CMAX, 1));
		offer(mk(0, CMAX, CMAX, CMAX, 1, 16'hFFFF, CMIN, CMIN, CMIN, 1));
		in_valid <= 1'b0;
		drain(5000);

		// directed: zero cutoff, single local atom
		set_config(17'd1, '0);
		offer(mk(1, 7, 7, 7, 1, 2, 7, 7, 7, 1));               // coincident, both ghosts
		offer(mk(1, -7, 9, 3, 1, 0, -7, 9, 3, 1));             // coincident, swapped owner
		offer(mk(0, 0, 0, 0, 1, 3, 1, 0, 0, 1));               // one LSB away, dropped
		in_valid <= 1'b0;
		drain(5000);

		// random phases over a spread of settings
		r = $urandom_range(1000, 8000);
		run_phase(local_t'($urandom_range(1, 1000)), dist_t'(longint'(r) * r), r, 180, 22, 0);
		r = $urandom_range(1, 16383);
		run_phase('0, dist_t'(longint'(r) * r), r, 180, 22, 0);
		run_phase(17'd65536, '0, 0, 180, 0, 0);
		run_phase(17'h1FFFF, dist_t'(DIST_TOP), 16383, 180, 22, 0);
		r = $urandom_range(100, 4000);
		run_phase(local_t'($urandom), dist_t'(longint'(r) * r), r, 180, 22, 1);
		r = $urandom_range(8000, 16383);
		run_phase(17'd65535, dist_t'(longint'(r) * r), r, 180, 22, 0);
		r = $urandom_range(1, 16383);
		run_phase(local_t'($urandom_range(0, 65535)), dist_t'(longint'(r) * r), r, 180, 22, 0);
		r = $urandom_range(1, 16383);
		run_phase(local_t'($urandom), dist_t'({$urandom, $urandom}), r, 180, 22, 0);

		sb.report_leftover();
		$display("covered %0d candidate beats in %0d segments over %0d register settings",
			sb.beats, sb.segments, settings);
		$display("%0d results checked, %0d with a contact, one %0d-cycle output hold",
			sb.checked, sb.contacts, HOLD_CYCLES);
		if (sb.errors == 0) begin
			$display("nearest_candidate_contact_select_unit_test: clean");
		end else begin
			$display("nearest_candidate_contact_select_unit_test: errors");
		end
		$finish;
	end

endmodule

// ----- nearest_candidate_contact_select_unit.f -----
rtl/ncc_pkg.sv
rtl/ncc_sqdist.sv
rtl/ncc_select.sv
rtl/nearest_candidate_contact_select_unit.sv
tb/nearest_candidate_contact_select_unit_test.sv
